@@ rtl/drm_pkg.sv @@
package drm_pkg;

	// Ring geometry
	localparam int WINDOW_SIZE  = 128;
	localparam int RING_WINDOWS = 32;
	localparam int MAX_SAMPLES  = 2048;

	// Field widths fixed by the interface
	localparam int WORD_W  = 16;
	localparam int IDX_W   = 11;
	localparam int START_W = 6;

	// Derived widths
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W  = $clog2(MAX_SAMPLES);
	localparam int WIN_W   = (RING_WINDOWS > 2) ? $clog2(RING_WINDOWS) : 1;
	localparam int SUM_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
	localparam int PROD_W  = $clog2(RING_WINDOWS * WINDOW_SIZE) + 1;
	localparam int DVD_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;
	localparam int STEP_W  = $clog2(DVD_W + 1);

	// Word flags and masks
	localparam logic [WORD_W-1:0] FLAG_START = 16'h2000;
	localparam logic [WORD_W-1:0] FLAG_STOP  = 16'h1000;
	localparam logic [WORD_W-1:0] LOW_MASK   = 16'h0fff;
	localparam logic [WORD_W-1:0] HIGH_MASK  = 16'hc000;

	// Function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic read_start;
		logic fin_start;
		logic div_step;
		logic rd_issue;
		logic put;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic count_zero;
		logic flag_found;
		logic div_last;
		logic op_read;
		logic out_free;
	} status_t;

endpackage

@@ rtl/digitizer_ring_unroller.sv @@
// Loads without the last flag: one beat per cycle while the input is not stalled, no result.
// Final load with a flag and reads: result valid after these steps in order
//   (final load: setup, 13 remainder steps, put; read: 13 remainder steps, store read, put).
// Final load without a flag: setup, then put; read on an empty channel: put only.
// Input stalls until the result is put.
// Reset clears the channel state and the output valid; the sample store is not cleared.
module digitizer_ring_unroller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [drm_pkg::WORD_W-1:0]    sample,
	input  logic                          last,
	input  logic                          event_first,
	input  logic [drm_pkg::IDX_W-1:0]     read_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [drm_pkg::WORD_W-1:0]    sample_out,
	output logic [drm_pkg::START_W-1:0]   start_window,
	output logic                          is_read
);

	import drm_pkg::*;

	cmd_t    cmd;
	status_t st;

	drm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.last     (last),
		.st       (st),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	drm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.sample       (sample),
		.last         (last),
		.event_first  (event_first),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.start_window (start_window),
		.is_read      (is_read)
	);

endmodule

@@ rtl/drm_ram.sv @@
module drm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/drm_ctrl.sv @@
module drm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             func,
	input  logic             last,
	input  drm_pkg::status_t st,
	output logic             in_stall,
	output drm_pkg::cmd_t    cmd
);

	import drm_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	// Sequence one item at a time
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func == FUNC_LOAD) begin
						cmd.load = 1'b1;
						if (last) begin
							state_d = S_START;
						end
					end else begin
						cmd.read_start = 1'b1;
						state_d = st.count_zero ? S_PUT : S_DIV;
					end
				end
			end
			S_START: begin
				cmd.fin_start = 1'b1;
				state_d = st.flag_found ? S_DIV : S_PUT;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = st.op_read ? S_RD : S_PUT;
				end
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_d = S_PUT;
			end
			S_PUT: begin
				if (st.out_free) begin
					cmd.put = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/drm_dp.sv @@
module drm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  drm_pkg::cmd_t                 cmd,
	output drm_pkg::status_t              st,
	input  logic [drm_pkg::WORD_W-1:0]    sample,
	input  logic                          last,
	input  logic                          event_first,
	input  logic [drm_pkg::IDX_W-1:0]     read_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [drm_pkg::WORD_W-1:0]    sample_out,
	output logic [drm_pkg::START_W-1:0]   start_window,
	output logic                          is_read
);

	import drm_pkg::*;

	// Channel state
	logic [CNT_W-1:0]   count_q;
	logic               high_half_q;
	logic               flag_found_q;
	logic               found_stop_q;
	logic [WIN_W-1:0]   found_win_q;
	logic [ADDR_W-1:0]  rotation_q;
	logic               closed_q;

	// Remainder unit and item context
	logic [DVD_W-1:0]   dvd_q;
	logic [CNT_W-1:0]   rem_q;
	logic [STEP_W-1:0]  step_q;
	logic               op_read_q;
	logic               mask_q;
	logic               zero_q;
	logic [START_W-1:0] report_q;

	// Output register
	logic               out_valid_q;
	logic [WORD_W-1:0]  sample_out_q;
	logic [START_W-1:0] start_window_q;
	logic               is_read_q;

	// Load path
	logic [CNT_W-1:0]   cnt_base;
	logic               ff_base;
	logic [CNT_W-1:0]   load_win;
	logic               at_edge;
	logic               has_room;
	logic               probe;
	logic               hit_start;
	logic               hit_stop;

	// Start window path
	logic [WIN_W-1:0]   nw;
	logic [WIN_W:0]     diff;
	logic [WIN_W-1:0]   start;
	logic [START_W-1:0] report;

	// Read path
	logic [DVD_W-1:0]   idx_x;
	logic [DVD_W-1:0]   cnt_x;
	logic               rd_mask;

	// Divider step
	logic [CNT_W:0]     trial;
	logic               trial_ge;
	logic [CNT_W-1:0]   rem_next;

	logic [WORD_W-1:0]  ram_rd_data;
	logic [WORD_W-1:0]  read_value;
	logic               out_free;

	// Start afresh on the first load after a closed channel
	assign cnt_base  = closed_q ? '0 : count_q;
	assign ff_base   = closed_q ? 1'b0 : flag_found_q;
	assign load_win  = CNT_W'(cnt_base / WINDOW_SIZE);
	assign at_edge   = (cnt_base % WINDOW_SIZE) == '0;
	assign has_room  = cnt_base < CNT_W'(MAX_SAMPLES);
	assign probe     = has_room && !ff_base && at_edge && (load_win < CNT_W'(RING_WINDOWS));
	assign hit_start = probe && ((sample & FLAG_START) != '0);
	assign hit_stop  = probe && !hit_start && ((sample & FLAG_STOP) != '0);

	// Resolve the start window, wrapping the stop case into the ring
	assign nw     = WIN_W'((count_q / WINDOW_SIZE) % RING_WINDOWS);
	assign diff   = (WIN_W+1)'(found_win_q) + (WIN_W+1)'(RING_WINDOWS) - (WIN_W+1)'(nw);
	assign start  = found_stop_q
		? ((diff >= (WIN_W+1)'(RING_WINDOWS)) ? WIN_W'(diff - (WIN_W+1)'(RING_WINDOWS))
			: WIN_W'(diff))
		: found_win_q;
	assign report = START_W'(start) + (high_half_q ? START_W'(RING_WINDOWS) : START_W'(0));

	// Mask the first and last window and the high half
	assign idx_x   = DVD_W'(read_index);
	assign cnt_x   = DVD_W'(count_q);
	assign rd_mask = high_half_q || (idx_x < DVD_W'(WINDOW_SIZE))
		|| (cnt_x < DVD_W'(WINDOW_SIZE)) || (idx_x >= cnt_x - DVD_W'(WINDOW_SIZE));

	// One restoring step of the remainder per cycle
	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign trial_ge = trial >= {1'b0, count_q};
	assign rem_next = trial_ge ? CNT_W'(trial - {1'b0, count_q}) : CNT_W'(trial);

	assign read_value = zero_q ? '0 : (mask_q ? (ram_rd_data & LOW_MASK) : ram_rd_data);
	assign out_free   = !out_valid_q || !out_stall;

	assign st.count_zero = (count_q == '0);
	assign st.flag_found = flag_found_q;
	assign st.div_last   = (step_q == STEP_W'(1));
	assign st.op_read    = op_read_q;
	assign st.out_free   = out_free;

	drm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.load && has_room),
		.wr_addr (cnt_base[ADDR_W-1:0]),
		.wr_data (sample),
		.rd_en   (cmd.rd_issue),
		.rd_addr (rem_q[ADDR_W-1:0]),
		.rd_data (ram_rd_data)
	);

	// Channel state and divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			high_half_q  <= 1'b0;
			flag_found_q <= 1'b0;
			found_stop_q <= 1'b0;
			found_win_q  <= '0;
			rotation_q   <= '0;
			closed_q     <= 1'b0;
			step_q       <= '0;
		end else begin
			if (cmd.load) begin
				if (event_first) begin
					high_half_q <= (sample & HIGH_MASK) != '0;
				end
				if (closed_q) begin
					rotation_q <= '0;
				end
				if (hit_start || hit_stop) begin
					flag_found_q <= 1'b1;
					found_stop_q <= hit_stop;
					found_win_q  <= load_win[WIN_W-1:0];
				end else if (closed_q) begin
					flag_found_q <= 1'b0;
					found_stop_q <= 1'b0;
					found_win_q  <= '0;
				end
				count_q  <= has_room ? cnt_base + CNT_W'(1) : cnt_base;
				closed_q <= last;
			end
			if (cmd.fin_start) begin
				step_q <= STEP_W'(DVD_W);
				if (!flag_found_q) begin
					rotation_q <= '0;
				end
			end
			if (cmd.read_start) begin
				step_q <= STEP_W'(DVD_W);
			end
			if (cmd.div_step) begin
				step_q <= step_q - STEP_W'(1);
				if ((step_q == STEP_W'(1)) && !op_read_q) begin
					rotation_q <= rem_next[ADDR_W-1:0];
				end
			end
		end
	end

	// Item context and remainder datapath
	always_ff @(posedge clk) begin
		if (cmd.fin_start) begin
			op_read_q <= 1'b0;
			report_q  <= flag_found_q ? report : '0;
			dvd_q     <= DVD_W'(start) * DVD_W'(WINDOW_SIZE);
			rem_q     <= '0;
		end
		if (cmd.read_start) begin
			op_read_q <= 1'b1;
			mask_q    <= rd_mask;
			zero_q    <= (count_q == '0);
			dvd_q     <= idx_x + DVD_W'(rotation_q);
			rem_q     <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			dvd_q <= dvd_q << 1;
		end
	end

	// Output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			sample_out_q   <= op_read_q ? read_value : '0;
			start_window_q <= op_read_q ? '0 : report_q;
			is_read_q      <= op_read_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = sample_out_q;
	assign start_window = start_window_q;
	assign is_read      = is_read_q;

	// A new beat never overwrites one still waiting
	a_put_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> (!out_valid_q || !out_stall))
		else $error("result overwrote a pending beat");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond store depth");

	a_rot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rotation_q == '0) || (CNT_W'(rotation_q) < count_q))
		else $error("rotation not reduced below sample count");

	a_cmd_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.read_start, cmd.fin_start,
			cmd.div_step, cmd.rd_issue, cmd.put}))
		else $error("more than one datapath command at once");

endmodule
